// File: hw/rtl/rlua_pkg.sv
`timescale 1ns / 1ps

package rlua_pkg;

   // Default table depth in four-byte units.
   localparam int NUM_UNITS_DEF = 256;

   // Width of a request size and of the size rounded up to whole units.
   localparam int SIZE_W = 16;
   localparam int NEED_W = 15;

   // Widths of the byte offsets on the ports and of the unit index taken from them.
   localparam int OFFSET_W = 10;
   localparam int FREE_UNIT_W = OFFSET_W - 2;

   // Packed widths of the stream payloads.
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 1;

   // Request kinds. The fourth code is reserved and ignored.
   localparam logic [REQ_USER_W-1:0] KIND_ALLOC = 2'd0;
   localparam logic [REQ_USER_W-1:0] KIND_FREE  = 2'd1;
   localparam logic [REQ_USER_W-1:0] KIND_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_PROBE
   } state_type;

endpackage

// File: hw/rtl/run_length_unit_allocator_top.sv
`timescale 1ns / 1ps

// First-fit allocator of contiguous runs of four-byte units over a table of
// NUM_UNITS entries, each entry holding the length of the block that starts
// there or zero. A request beat carries its kind in req_tuser: allocate rounds
// the byte size up to units, scans from unit 0 skipping each recorded block
// plus one guard unit, records the length at the first fitting start and
// returns that start as a byte offset on one response beat (alloc_failed set
// and offset zero when the run would end past unit NUM_UNITS-2). A size of
// zero returns the first free start and records nothing. Free zeroes the
// entry of its offset and clear zeroes the whole table; neither answers.
// The table lives in a memory with one write port and a registered read
// port, and one sequencer reuses the same adder and comparator for every
// entry it visits. An allocate therefore examines the table entries one
// after another in the start and probe states; a free is done as it is
// accepted. After reset and after each clear beat the block sweeps the
// whole table, one entry a cycle, and holds req_tready low meanwhile. The
// block works on one request at a time and takes the next request only when
// the response register is empty or being drained in the same cycle.
module run_length_unit_allocator_top
   import rlua_pkg::*;
#(
   parameter int NUM_UNITS = NUM_UNITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // req_tdata fields from bit 0: request_size[15:0], free_offset[25:16], zero pad.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser fields from bit 0: kind[1:0].
   input  logic [REQ_USER_W-1:0] req_tuser,
   // Response channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata fields from bit 0: alloc_offset[9:0], zero pad.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser fields from bit 0: alloc_failed.
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   // Address, entry, scan-position and stop-sum widths. A position can run
   // to just under twice the depth when a jump goes past the end of the table.
   localparam int AW = $clog2(NUM_UNITS);
   localparam int EW = AW;
   localparam int PW = AW + 1;
   localparam int SW = ((PW > NEED_W) ? PW : NEED_W) + 1;

   // Request payload fields.
   logic [REQ_USER_W-1:0]  req_kind;
   logic [SIZE_W-1:0]      req_size;
   logic [OFFSET_W-1:0]    req_free_offset;
   logic [FREE_UNIT_W-1:0] free_unit;
   logic [SIZE_W:0]        size_sum;
   logic [NEED_W-1:0]      need_units;
   logic                   free_in_range;

   // Sequencer state.
   state_type              state_ff, state_in;
   logic [PW-1:0]          cur_ff, cur_in;
   logic [PW-1:0]          pos_ff, pos_in;
   logic [PW-1:0]          stop_ff, stop_in;
   logic [NEED_W-1:0]      need_ff, need_in;
   logic [AW-1:0]          clr_cnt_ff, clr_cnt_in;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_W-1:0]    rsp_offset_ff, rsp_offset_in;
   logic                   rsp_failed_ff, rsp_failed_in;

   // Table memory.
   logic [EW-1:0]          table_mem [NUM_UNITS];
   logic [EW-1:0]          rd_data_ff;
   logic [AW-1:0]          rd_addr;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [EW-1:0]          mem_wdata;

   // Shared scan arithmetic.
   logic                   req_hs;
   logic                   rsp_hs;
   logic                   entry_nz;
   logic                   cur_oob;
   logic [PW-1:0]          jump_pos;
   logic [PW-1:0]          probe_next;
   logic                   probe_last;
   logic [SW-1:0]          stop_sum;
   logic                   stop_over;
   logic                   need_small;

   assign req_kind        = req_tuser;
   assign req_size        = req_tdata[SIZE_W-1:0];
   assign req_free_offset = req_tdata[SIZE_W +: OFFSET_W];
   assign free_unit       = req_free_offset[OFFSET_W-1:2];
   assign free_in_range   = 32'(free_unit) < 32'(NUM_UNITS);

   // Round the byte size up to whole units.
   assign size_sum   = (SIZE_W+1)'(req_size) + (SIZE_W+1)'(3);
   assign need_units = size_sum[SIZE_W:2];

   assign req_hs = req_tvalid & req_tready;
   assign rsp_hs = rsp_valid_ff & rsp_tready;

   // In the start state the cursor is the candidate start; in the probe state
   // it is the unit being checked inside the candidate run. Either way a
   // nonzero entry sends the scan one unit past the end of that block.
   assign entry_nz   = rd_data_ff != '0;
   assign cur_oob    = cur_ff >= PW'(NUM_UNITS);
   assign jump_pos   = cur_ff + PW'(rd_data_ff) + PW'(1);
   assign probe_next = cur_ff + PW'(1);
   assign probe_last = probe_next == stop_ff;
   assign stop_sum   = SW'(cur_ff) + SW'(need_ff);
   assign stop_over  = stop_sum > SW'(NUM_UNITS - 1);
   assign need_small = need_ff <= NEED_W'(1);

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == AW'(NUM_UNITS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_hs) begin
               if (req_kind == KIND_ALLOC) begin
                  state_in = ST_START;
               end else if (req_kind == KIND_CLEAR) begin
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_START: begin
            if (cur_oob) begin
               state_in = ST_IDLE;
            end else if (entry_nz) begin
               state_in = ST_START;
            end else if (stop_over || need_small) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (entry_nz) begin
               state_in = ST_START;
            end else if (probe_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Datapath, memory port and response register controls.
   always_comb begin
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      stop_in       = stop_ff;
      need_in       = need_ff;
      clr_cnt_in    = clr_cnt_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_offset_in = rsp_offset_ff;
      rsp_failed_in = rsp_failed_ff;
      mem_we        = 1'b0;
      mem_waddr     = cur_ff[AW-1:0];
      mem_wdata     = EW'(need_ff);
      req_tready    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
         end
         ST_IDLE: begin
            req_tready = ~rsp_valid_ff | rsp_tready;
            if (req_hs) begin
               unique case (req_kind)
                  KIND_ALLOC: begin
                     need_in = need_units;
                     cur_in  = '0;
                  end
                  KIND_FREE: begin
                     mem_we    = free_in_range;
                     mem_waddr = AW'(free_unit);
                     mem_wdata = '0;
                  end
                  KIND_CLEAR: begin
                     clr_cnt_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_START: begin
            if (cur_oob) begin
               rsp_valid_in  = 1'b1;
               rsp_offset_in = '0;
               rsp_failed_in = 1'b1;
            end else if (entry_nz) begin
               cur_in = jump_pos;
            end else if (stop_over) begin
               rsp_valid_in  = 1'b1;
               rsp_offset_in = '0;
               rsp_failed_in = 1'b1;
            end else if (need_small) begin
               // A run of zero or one unit fits at once; a zero size records nothing.
               mem_we        = need_ff != '0;
               mem_waddr     = cur_ff[AW-1:0];
               rsp_valid_in  = 1'b1;
               rsp_offset_in = OFFSET_W'({cur_ff, 2'b00});
               rsp_failed_in = 1'b0;
            end else begin
               pos_in  = cur_ff;
               stop_in = stop_sum[PW-1:0];
               cur_in  = probe_next;
            end
         end
         ST_PROBE: begin
            if (entry_nz) begin
               cur_in = jump_pos;
            end else if (probe_last) begin
               mem_we        = 1'b1;
               mem_waddr     = pos_ff[AW-1:0];
               rsp_valid_in  = 1'b1;
               rsp_offset_in = OFFSET_W'({pos_ff, 2'b00});
               rsp_failed_in = 1'b0;
            end else begin
               cur_in = probe_next;
            end
         end
         default: begin
         end
      endcase
   end

   // The read address follows the next cursor so that the entry is ready
   // when the sequencer looks at it in the following cycle.
   assign rd_addr = cur_in[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      pos_ff        <= pos_in;
      stop_ff       <= stop_in;
      need_ff       <= need_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_failed_ff <= rsp_failed_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_offset_ff);
   assign rsp_tuser  = rsp_failed_ff;

endmodule

// File: hw/rtl/rlua_checker.sv
`timescale 1ns / 1ps

module rlua_checker
   import rlua_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_USER_W-1:0] req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   // A stalled response beat stays and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response beat changed");

   // The table sweep after reset keeps requests out.
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request channel ready right after reset");

   // An allocate or clear beat keeps the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == KIND_ALLOC || req_tuser == KIND_CLEAR)
      |=> !req_tready)
      else $error("request accepted while a scan or sweep was due");

   // A failed allocation reports offset zero.
   a_fail_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[OFFSET_W-1:0] == '0)
      else $error("failed allocation with nonzero offset");

endmodule

bind run_length_unit_allocator_top rlua_checker u_rlua_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
